// ----- design/amdfs_pkg.sv -----
`default_nettype none

package amdfs_pkg;

  // Width of a vertex number on the ports.
  localparam int VTX_W = 4;
  // Vertex numbers fit four bits, so no more than sixteen lanes are ever live.
  localparam int LANE_CAP = 16;
  // Width of the vertex count register.
  localparam int CNT_W = 5;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_VISIT   = 2'd0,
    STAT_EDGE    = 2'd1,
    STAT_CLEARED = 2'd2,
    STAT_RANGE   = 2'd3
  } status_t;

  // Operations that the sequencer hands to the graph datapath.
  typedef enum logic [2:0] {
    G_NONE,
    G_INSERT,
    G_CLEAR,
    G_DFS_INIT,
    G_SCAN
  } graph_op_t;

  // What a microcode step sends to the output register.
  typedef enum logic [1:0] {
    EM_NONE,
    EM_STATUS,
    EM_VISIT,
    EM_FINAL
  } emit_t;

  // How a microcode step picks its successor.
  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_DISPATCH,
    J_BAD,
    J_SCAN
  } jump_t;

  typedef logic [2:0] step_t;

  localparam step_t U_FETCH  = 3'd0;
  localparam step_t U_INS    = 3'd1;
  localparam step_t U_INS_OK = 3'd2;
  localparam step_t U_CLR    = 3'd3;
  localparam step_t U_DFS    = 3'd4;
  localparam step_t U_SCAN   = 3'd5;
  localparam step_t U_ERR    = 3'd6;
  localparam step_t U_FLUSH  = 3'd7;

  typedef struct packed {
    logic      in_rdy;
    graph_op_t gop;
    emit_t     emit;
    status_t   st;
    jump_t     jump;
    step_t     target;
  } ctrl_word_t;

  // Command bundle from the sequencer to the graph datapath.
  typedef struct packed {
    graph_op_t          op;
    logic [VTX_W-1:0]   a;
    logic [VTX_W-1:0]   b;
    logic [CNT_W-1:0]   n;
  } graph_ctrl_t;

  // Status bundle from the graph datapath back to the sequencer.
  typedef struct packed {
    logic             found;
    logic             empty;
    logic [VTX_W-1:0] pick;
  } graph_stat_t;

  // The microprogram: one control word per step.
  function automatic ctrl_word_t ucode(input step_t step);
    ctrl_word_t w;
    w = '{in_rdy: 1'b0, gop: G_NONE, emit: EM_NONE, st: STAT_VISIT,
          jump: J_GOTO, target: U_FETCH};
    unique case (step)
      U_FETCH: begin
        w.in_rdy = 1'b1;
        w.jump   = J_DISPATCH;
      end
      U_INS: begin
        w.jump   = J_BAD;
        w.target = U_ERR;
      end
      U_INS_OK: begin
        w.gop  = G_INSERT;
        w.emit = EM_STATUS;
        w.st   = STAT_EDGE;
      end
      U_CLR: begin
        w.gop  = G_CLEAR;
        w.emit = EM_STATUS;
        w.st   = STAT_CLEARED;
      end
      U_DFS: begin
        w.gop    = G_DFS_INIT;
        w.jump   = J_BAD;
        w.target = U_ERR;
      end
      U_SCAN: begin
        w.gop    = G_SCAN;
        w.emit   = EM_VISIT;
        w.jump   = J_SCAN;
        w.target = U_FLUSH;
      end
      U_ERR: begin
        w.emit = EM_STATUS;
        w.st   = STAT_RANGE;
      end
      U_FLUSH: begin
        w.emit = EM_FINAL;
      end
      default: begin
        w.jump = J_GOTO;
      end
    endcase
    return w;
  endfunction

  // Entry step for each action of an accepted word.
  function automatic step_t dispatch(input action_t act);
    step_t s;
    unique case (act)
      ACT_INSERT: s = U_INS;
      ACT_SEARCH: s = U_DFS;
      ACT_CLEAR:  s = U_CLR;
      default:    s = U_FETCH;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- design/amdfs_graph.sv -----
`default_nettype none

module amdfs_graph
  import amdfs_pkg::*;
#(
  parameter int MAX_NODES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire graph_ctrl_t ctrl,
  output graph_stat_t      stat
);

  localparam int NODE_CAP = (MAX_NODES < LANE_CAP) ? MAX_NODES : LANE_CAP;
  localparam int IDX_W    = (NODE_CAP > 1) ? $clog2(NODE_CAP) : 1;
  localparam int DEP_W    = $clog2(NODE_CAP + 1);

  logic [NODE_CAP-1:0] adj [NODE_CAP];
  logic [NODE_CAP-1:0] visited;
  logic [VTX_W-1:0]    stack [NODE_CAP];
  logic [DEP_W-1:0]    depth;

  logic [DEP_W-1:0]    depth_m1;
  logic [IDX_W-1:0]    top_idx;
  logic [IDX_W-1:0]    push_idx;
  logic [VTX_W-1:0]    node;
  logic [NODE_CAP-1:0] row;
  logic [NODE_CAP-1:0] nmask;
  logic [NODE_CAP-1:0] cand;
  logic [IDX_W-1:0]    a_i;
  logic [IDX_W-1:0]    b_i;
  logic [IDX_W-1:0]    pick_i;

  assign a_i      = ctrl.a[IDX_W-1:0];
  assign b_i      = ctrl.b[IDX_W-1:0];
  assign depth_m1 = depth - 1'b1;
  assign top_idx  = depth_m1[IDX_W-1:0];
  assign push_idx = depth[IDX_W-1:0];
  assign node     = stack[top_idx];
  assign row      = adj[node[IDX_W-1:0]];

  // Unvisited neighbors of the vertex on top of the stack, inside the count.
  always_comb begin
    for (int i = 0; i < NODE_CAP; i++) begin
      nmask[i] = (CNT_W'(i) < ctrl.n);
    end
    cand = row & ~visited & nmask;
  end

  // Lowest-numbered candidate wins.
  always_comb begin
    pick_i = '0;
    for (int i = NODE_CAP - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick_i = IDX_W'(i);
      end
    end
  end

  assign stat.found = |cand;
  assign stat.empty = (depth == '0);
  assign stat.pick  = VTX_W'(pick_i);

  // Adjacency matrix: both bits of an edge are set together.
  always_ff @(posedge clk) begin
    if (rst || ctrl.op == G_CLEAR) begin
      for (int i = 0; i < NODE_CAP; i++) begin
        adj[i] <= '0;
      end
    end else if (ctrl.op == G_INSERT) begin
      adj[a_i][b_i] <= 1'b1;
      adj[b_i][a_i] <= 1'b1;
    end
  end

  // Visited set and stack depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      depth   <= '0;
    end else if (ctrl.op == G_DFS_INIT) begin
      visited <= NODE_CAP'(1) << a_i;
      depth   <= DEP_W'(1);
    end else if (ctrl.op == G_SCAN) begin
      if (stat.found) begin
        visited[pick_i] <= 1'b1;
        depth           <= depth + 1'b1;
      end else begin
        depth <= depth_m1;
      end
    end
  end

  // Path stack entries.
  always_ff @(posedge clk) begin
    if (ctrl.op == G_DFS_INIT) begin
      stack[0] <= ctrl.a;
    end else if (ctrl.op == G_SCAN && stat.found) begin
      stack[push_idx] <= stat.pick;
    end
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEP_W'(NODE_CAP))
    else $error("stack depth exceeds vertex capacity");

  a_pick_in_range: assert property (@(posedge clk) disable iff (rst)
    stat.found |-> ({1'b0, stat.pick} < ctrl.n))
    else $error("picked neighbor outside vertex count");

  a_push_marks: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == G_SCAN && stat.found) |=>
      ($countones(visited) == $past($countones(visited)) + 1))
    else $error("push did not mark exactly one new vertex");
`endif

endmodule

`default_nettype wire

// ----- design/adjacency_matrix_dfs_engine_unit.sv -----
`default_nettype none

// Channel    Dir  Handshake                     Payload
// s_axis     in   s_axis_tvalid/s_axis_tready   tdata: action, vertex, other_end
// m_axis     out  m_axis_tvalid/m_axis_tready   tdata: visited_vertex, status; tlast
// cfg        in   cfg_valid/cfg_ready           cfg_data: vertex_count
//
// Clear words pass through fetch and one microcode step. Insert and out-of-range
// words pass through fetch, the range check step and the store or error step.
// A search makes one neighbor pick and one stack push or pop per cycle, except while
// the output register stalls it. A full output register, when the step has a word to emit,
// freezes the microcode step counter and all datapath state.
// Synchronous reset empties the matrix, zeroes the vertex count and returns to fetch.

module adjacency_matrix_dfs_engine_unit
  import amdfs_pkg::*;
#(
  parameter int MAX_NODES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [1:0] action, [5:2] vertex, [9:6] other_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [3:0] visited_vertex, [5:4] status
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data
);

  localparam int NODE_CAP = (MAX_NODES < LANE_CAP) ? MAX_NODES : LANE_CAP;

  step_t            upc;
  step_t            upc_next;
  ctrl_word_t       cw;
  logic [CNT_W-1:0] vertex_count;
  logic [CNT_W-1:0] n;

  action_t          act;
  logic [VTX_W-1:0] va;
  logic [VTX_W-1:0] vb;
  logic [VTX_W-1:0] pend;
  logic             bad;

  logic             out_valid;
  logic [VTX_W-1:0] out_vertex;
  status_t          out_status;
  logic             out_last;

  logic             in_fire;
  logic             emit_want;
  logic             out_free;
  logic             stall;
  graph_ctrl_t      gctl;
  graph_stat_t      gstat;

  // Configuration register; always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_valid) begin
      vertex_count <= cfg_data;
    end
  end

  assign n = (vertex_count > CNT_W'(NODE_CAP)) ? CNT_W'(NODE_CAP) : vertex_count;

  // Current control word and handshake terms.
  assign cw            = ucode(upc);
  assign s_axis_tready = cw.in_rdy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  assign bad = ({1'b0, va} >= n) || (act == ACT_INSERT && {1'b0, vb} >= n);

  always_comb begin
    case (cw.emit)
      EM_STATUS, EM_FINAL: emit_want = 1'b1;
      EM_VISIT:            emit_want = gstat.found && !gstat.empty;
      default:             emit_want = 1'b0;
    endcase
  end

  assign stall = emit_want && !out_free;

  // Step counter sequencing.
  always_comb begin
    unique case (cw.jump)
      J_NEXT:     upc_next = upc + 3'd1;
      J_GOTO:     upc_next = cw.target;
      J_DISPATCH: upc_next = in_fire ? dispatch(action_t'(s_axis_tdata[1:0])) : upc;
      J_BAD:      upc_next = bad ? cw.target : upc + 3'd1;
      J_SCAN:     upc_next = gstat.empty ? cw.target : upc;
      default:    upc_next = U_FETCH;
    endcase
    if (stall) begin
      upc_next = upc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

  // Operands of the accepted word.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act <= action_t'(s_axis_tdata[1:0]);
      va  <= s_axis_tdata[5:2];
      vb  <= s_axis_tdata[9:6];
    end
  end

  // Datapath command, suppressed when stalled or when the step's guard fails.
  always_comb begin
    gctl.op = cw.gop;
    gctl.a  = va;
    gctl.b  = vb;
    gctl.n  = n;
    if (stall || (cw.gop == G_DFS_INIT && bad) || (cw.gop == G_SCAN && gstat.empty)) begin
      gctl.op = G_NONE;
    end
  end

  amdfs_graph #(
    .MAX_NODES(MAX_NODES)
  ) u_graph (
    .clk  (clk),
    .rst  (rst),
    .ctrl (gctl),
    .stat (gstat)
  );

  // The newest visited vertex waits here until it is known whether it is the last.
  always_ff @(posedge clk) begin
    if (gctl.op == G_DFS_INIT) begin
      pend <= va;
    end else if (gctl.op == G_SCAN && gstat.found) begin
      pend <= gstat.pick;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_want && !stall) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_want && !stall) begin
      case (cw.emit)
        EM_VISIT: begin
          out_vertex <= pend;
          out_status <= STAT_VISIT;
          out_last   <= 1'b0;
        end
        EM_FINAL: begin
          out_vertex <= pend;
          out_status <= STAT_VISIT;
          out_last   <= 1'b1;
        end
        default: begin
          out_vertex <= '0;
          out_status <= cw.st;
          out_last   <= 1'b1;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_status, out_vertex};
  assign m_axis_tlast  = out_last;

`ifndef SYNTHESIS
  a_visit_in_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[5:4] == STAT_VISIT) |-> ({1'b0, m_axis_tdata[3:0]} < n))
    else $error("visited vertex outside vertex count");

  a_status_zero_vertex: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[5:4] != STAT_VISIT) |-> (m_axis_tdata[3:0] == '0))
    else $error("non-visit result carries a vertex");

  a_fetch_stack_empty: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> gstat.empty)
    else $error("new word taken while the search stack is live");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import amdfs_pkg::*;

  localparam int GRAPH_NODES   = 16;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_WORDS  = 380;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int REPORT_LIMIT  = 10;

  // One result word as the search engine should produce it.
  typedef struct {
    logic [3:0] vtx;
    status_t    st;
    logic       is_last;
  } dfs_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [1:0] action, [5:2] vertex, [9:6] other_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [3:0] visited_vertex, [5:4] status
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;

  // Shadow copy of the graph state used to predict results.
  logic [GRAPH_NODES-1:0] adj_rows [GRAPH_NODES];
  logic [4:0]             vertex_count_shadow;
  dfs_result_t            pending_results [$];

  int unsigned mismatches  = 0;
  int unsigned words_sent  = 0;
  int unsigned cycle_count = 0;
  bit          no_idle     = 1'b0;

  adjacency_matrix_dfs_engine_unit #(.MAX_NODES(GRAPH_NODES)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void push_result(logic [3:0] vtx, status_t st, logic is_last);
    dfs_result_t r;
    r.vtx     = vtx;
    r.st      = st;
    r.is_last = is_last;
    pending_results.push_back(r);
  endfunction

  // Computes the result words of one accepted input word and updates the shadow graph.
  function automatic void predict_word(action_t act, logic [3:0] va, logic [3:0] vb);
    int          n;
    int          depth;
    int          hits;
    int          top;
    int          w;
    bit          found;
    logic [3:0]  node;
    logic [15:0] seen;
    logic [3:0]  stack_vtx  [GRAPH_NODES];
    int          stack_next [GRAPH_NODES];
    logic [3:0]  visit_order [16];
    n = (vertex_count_shadow > 5'd16) ? 16 : int'(vertex_count_shadow);
    case (act)
      ACT_INSERT: begin
        if (va >= n || vb >= n) begin
          push_result(4'd0, STAT_RANGE, 1'b1);
        end else begin
          adj_rows[va][vb] = 1'b1;
          adj_rows[vb][va] = 1'b1;
          push_result(4'd0, STAT_EDGE, 1'b1);
        end
      end
      ACT_CLEAR: begin
        foreach (adj_rows[i]) adj_rows[i] = '0;
        push_result(4'd0, STAT_CLEARED, 1'b1);
      end
      ACT_SEARCH: begin
        if (va >= n) begin
          push_result(4'd0, STAT_RANGE, 1'b1);
        end else begin
          // Iterative DFS: each stack entry remembers the next neighbor to try.
          seen = '0;
          seen[va] = 1'b1;
          visit_order[0] = va;
          hits = 1;
          stack_vtx[0] = va;
          stack_next[0] = 0;
          depth = 1;
          while (depth > 0) begin
            top = depth - 1;
            node = stack_vtx[top];
            w = stack_next[top];
            found = 1'b0;
            while (w < n) begin
              if (adj_rows[node][w] && !seen[w]) begin
                found = 1'b1;
                break;
              end
              w++;
            end
            if (found && depth < GRAPH_NODES && hits < 16) begin
              stack_next[top] = w + 1;
              seen[w] = 1'b1;
              visit_order[hits] = w[3:0];
              hits++;
              stack_vtx[depth] = w[3:0];
              stack_next[depth] = 0;
              depth++;
            end else begin
              depth--;
            end
          end
          for (int i = 0; i < hits; i++) begin
            push_result(visit_order[i], STAT_VISIT, i == hits - 1);
          end
        end
      end
      default: begin
        // The unused action produces nothing.
      end
    endcase
  endfunction

  function automatic void report_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  // Compares one received word against the oldest expectation.
  function automatic void check_result(logic [3:0] vtx, logic [1:0] st, logic is_last);
    dfs_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected word: vertex %0d status %0d last %0b",
                                vtx, st, is_last));
    end else begin
      want = pending_results.pop_front();
      if (want.vtx !== vtx || want.st !== st || want.is_last !== is_last) begin
        report_mismatch($sformatf(
          "word differs: expected vertex %0d status %0d last %0b, got %0d %0d %0b",
          want.vtx, want.st, want.is_last, vtx, st, is_last));
      end
    end
  endfunction

  // Output side: random back-pressure and checking of every accepted word.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 30);
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata[3:0], m_axis_tdata[5:4], m_axis_tlast);
      end
    end
  end

  // Sends one word, with random idle cycles ahead of it.
  task automatic send_word(action_t act, logic [3:0] va, logic [3:0] vb);
    while (!no_idle && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, vb, va, act};
    do @(posedge clk); while (!s_axis_tready);
    predict_word(act, va, vb);
    if (act != ACT_NONE) words_sent++;
  endtask

  // Stops input and waits until the engine has delivered everything and gone quiet.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(logic [4:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    vertex_count_shadow = value;
  endtask

  function automatic logic [3:0] pick_vertex(int n);
    return (n == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(n - 1));
  endfunction

  // With no vertices in use every insert and search is out of range.
  task automatic test_zero_vertices();
    send_word(ACT_INSERT, 4'd0, 4'd0);
    send_word(ACT_SEARCH, 4'd0, 4'd0);
    send_word(ACT_CLEAR, 4'd15, 4'd15);
    send_word(ACT_NONE, 4'd15, 4'd15);
  endtask

  // Full-size graph: extreme vertices, a self loop and an isolated start.
  task automatic test_full_graph();
    write_vertex_count(5'd16);
    send_word(ACT_INSERT, 4'd0, 4'd15);
    send_word(ACT_INSERT, 4'd15, 4'd7);
    send_word(ACT_INSERT, 4'd3, 4'd3);
    send_word(ACT_INSERT, 4'd7, 4'd2);
    send_word(ACT_SEARCH, 4'd0, 4'd0);
    send_word(ACT_SEARCH, 4'd3, 4'd0);
    send_word(ACT_SEARCH, 4'd15, 4'd0);
  endtask

  // A count above the limit behaves as the full sixteen vertices.
  task automatic test_count_above_limit();
    write_vertex_count(5'd31);
    send_word(ACT_INSERT, 4'd15, 4'd14);
    send_word(ACT_SEARCH, 4'd14, 4'd9);
    send_word(ACT_NONE, 4'd10, 4'd5);
  endtask

  // Small count: endpoints and starts beyond it are rejected, clear drops edges.
  task automatic test_small_count();
    write_vertex_count(5'd4);
    send_word(ACT_INSERT, 4'd3, 4'd15);
    send_word(ACT_INSERT, 4'd2, 4'd1);
    send_word(ACT_SEARCH, 4'd4, 4'd0);
    send_word(ACT_SEARCH, 4'd2, 4'd0);
    send_word(ACT_CLEAR, 4'd0, 4'd0);
    send_word(ACT_SEARCH, 4'd0, 4'd0);
  endtask

  // Phases of random graphs; each phase picks a count, builds edges and searches.
  task automatic test_random_graphs();
    int unsigned target;
    int          phase;
    int          phase_len;
    int          n;
    int          r;
    int          tmp;
    int          j;
    logic [4:0]  cnt;
    int          perm [GRAPH_NODES];
    target = words_sent + RANDOM_WORDS;
    phase = 0;
    while (words_sent < target) begin
      case ($urandom_range(8))
        0:       cnt = 5'd0;
        1:       cnt = 5'd1;
        2:       cnt = 5'd2;
        3, 4:    cnt = 5'd16;
        5:       cnt = 5'($urandom_range(17, 31));
        default: cnt = 5'($urandom_range(3, 15));
      endcase
      write_vertex_count(cnt);
      no_idle = (phase >= 4 && phase <= 6);
      n = (cnt > 5'd16) ? 16 : int'(cnt);

      // Sometimes lay a path through every vertex so a search visits them all.
      if (n >= 2 && $urandom_range(2) == 0) begin
        for (int i = 0; i < n; i++) perm[i] = i;
        for (int i = n - 1; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        send_word(ACT_CLEAR, 4'($urandom_range(15)), 4'($urandom_range(15)));
        for (int i = 0; i + 1 < n; i++) begin
          send_word(ACT_INSERT, 4'(perm[i]), 4'(perm[i + 1]));
        end
        send_word(ACT_SEARCH, pick_vertex(n), 4'($urandom_range(15)));
      end

      phase_len = $urandom_range(20, 40);
      for (int i = 0; i < phase_len; i++) begin
        r = $urandom_range(99);
        if (r < 45)
          send_word(ACT_INSERT, pick_vertex(n), pick_vertex(n));
        else if (r < 75)
          send_word(ACT_SEARCH, pick_vertex(n), 4'($urandom_range(15)));
        else if (r < 80)
          send_word(ACT_CLEAR, 4'($urandom_range(15)), 4'($urandom_range(15)));
        else if (r < 88)
          send_word(ACT_INSERT, 4'($urandom_range(15)), 4'($urandom_range(15)));
        else if (r < 93)
          send_word(ACT_SEARCH, 4'($urandom_range(15)), 4'($urandom_range(15)));
        else if (r < 97)
          send_word(ACT_NONE, 4'($urandom_range(15)), 4'($urandom_range(15)));
        else
          send_word(action_t'($urandom_range(3)), 4'($urandom_range(15)),
                    4'($urandom_range(15)));
      end
      phase++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    foreach (adj_rows[i]) adj_rows[i] = '0;
    vertex_count_shadow = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_zero_vertices();
    test_full_graph();
    test_count_above_limit();
    test_small_count();
    test_random_graphs();

    wait_idle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
design/amdfs_pkg.sv
design/amdfs_graph.sv
design/adjacency_matrix_dfs_engine_unit.sv
verif/tb_top.sv
